/* hdl/iepq_pkg.sv */
// ----------------------------------------------------------------------------
// iepq_pkg
// shared constants and types of the input event packet queue
// ----------------------------------------------------------------------------
package iepq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int MAX_READ_DEF = 64;

    localparam logic [15:0] TYPE_SYNC    = 16'd0;
    localparam logic [15:0] CODE_REPORT  = 16'd0;
    localparam logic [15:0] CODE_DROPPED = 16'd3;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_DISCARD = 2'd3;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [2:0] SIZE_RESET = 3'd6;

    // one stored event: stamp 52 bits, payload 64 bits
    typedef struct packed {
        logic [31:0] sec;
        logic [19:0] usec;
        logic [15:0] ev_type;
        logic [15:0] code;
        logic [31:0] value;
    } t_event;

    // memory access request from the controller
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

/* hdl/input_event_packet_queue_unit.sv */
// ----------------------------------------------------------------------------
// input_event_packet_queue_unit
// packet-grouped ring of input events held in one synchronous memory
// ----------------------------------------------------------------------------
// usage: pulse start with an op while busy is low. push writes the event
// (a report with no events since the packet end is rejected) and also a
// dropped marker when the ring overflows; discard answers in the cycle of
// its transfer on an empty ring, else it writes like push at the read
// pointer; read does one memory read per event through the registered read
// port; flush reads each entry between read and write pointers and then
// possibly copies it through the single write port. a flush of the sync
// type answers in the cycle of its transfer. every result appears on o_*
// for one cycle with o_strobe high; the receiver cannot stall, so capture
// each transfer as it comes. o_last marks the final transfer of an op.
// writing the size register (i_cfg_we) clears r_wp, r_rp and r_pe.
// ----------------------------------------------------------------------------
module input_event_packet_queue_unit #(
    parameter int DEPTH    = iepq_pkg::DEPTH_DEF,
    parameter int MAX_READ = iepq_pkg::MAX_READ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_ev_sec,
    input  logic [19:0] i_ev_usec,
    input  logic [15:0] i_ev_type,
    input  logic [15:0] i_ev_code,
    input  logic signed [31:0] i_ev_value,
    input  logic [6:0]  i_max_count,
    output logic        o_strobe,
    output logic        o_out_valid,
    output logic [31:0] o_out_sec,
    output logic [19:0] o_out_usec,
    output logic [15:0] o_out_type,
    output logic [15:0] o_out_code,
    output logic signed [31:0] o_out_value,
    output logic [1:0]  o_status,
    output logic        o_last
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_READ + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_DROP  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_FRD   = 7'b0010000,
        S_FCHK  = 7'b0100000,
        S_FDONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp, r_pe, n_pe;
    logic [AW-1:0] r_mask, r_i, n_i, r_dst, n_dst;
    logic          r_run0, n_run0;
    logic          r_rd_pend, n_rd_pend;
    logic [CW-1:0] r_cnt, n_cnt, r_lim, n_lim;
    iepq_pkg::t_event r_ev, n_ev;
    logic [15:0]   r_ftype, n_ftype;
    logic [1:0]    r_pst, n_pst;

    iepq_pkg::t_mem_ctl mctl;
    logic [AW-1:0] waddr, raddr;
    iepq_pkg::t_event wdata, rdata;

    // effective ring mask from the size register, never above the memory depth
    localparam int SZ_RST = (int'(iepq_pkg::SIZE_RESET) > AW) ? AW
                                                              : int'(iepq_pkg::SIZE_RESET);
    localparam logic [AW-1:0] MASK_RST = AW'((1 << SZ_RST) - 1);

    logic [2:0]    szc;
    logic [AW-1:0] n_mask;

    always_comb begin
        szc = (i_cfg_wdata < 3'd2) ? 3'd2 : ((i_cfg_wdata > 3'd6) ? 3'd6 : i_cfg_wdata);
        if (int'(szc) > AW) begin
            n_mask = AW'((1 << AW) - 1);
        end else begin
            n_mask = AW'((1 << szc) - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RST;
        end else if (i_cfg_we) begin
            r_mask <= n_mask;
        end
    end

    iepq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_ctl(mctl), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic is_rep(iepq_pkg::t_event e);
        return e.ev_type == iepq_pkg::TYPE_SYNC && e.code == iepq_pkg::CODE_REPORT;
    endfunction

    logic [AW-1:0] wp1, rd_next;
    logic [CW-1:0] lim_in;
    iepq_pkg::t_event in_ev, drop_ev;

    always_comb begin
        in_ev = '{i_ev_sec, i_ev_usec, i_ev_type, i_ev_code, i_ev_value};
        lim_in = (i_max_count > 7'(MAX_READ)) ? CW'(MAX_READ) : CW'(i_max_count);
        wp1 = (r_wp + 1'b1) & r_mask;
        rd_next = (r_rp + 1'b1) & r_mask;
        drop_ev = '{r_ev.sec, r_ev.usec, iepq_pkg::TYPE_SYNC, iepq_pkg::CODE_DROPPED, 32'd0};

        n_state = r_state; n_wp = r_wp; n_rp = r_rp; n_pe = r_pe;
        n_i = r_i; n_dst = r_dst; n_run0 = r_run0; n_rd_pend = 1'b0;
        n_cnt = r_cnt; n_lim = r_lim; n_ev = r_ev; n_ftype = r_ftype; n_pst = r_pst;
        mctl = '0; waddr = r_wp; wdata = r_ev; raddr = r_rp;
        o_strobe = 1'b0; o_out_valid = 1'b0; o_status = '0; o_last = 1'b0;
        o_out_sec = '0; o_out_usec = '0; o_out_type = '0; o_out_code = '0; o_out_value = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ev = in_ev; n_ftype = i_ev_type; n_lim = lim_in; n_cnt = '0;
                    case (i_op)
                        iepq_pkg::OP_PUSH: n_state = S_PUSH;
                        iepq_pkg::OP_DISCARD: begin
                            if (r_wp != r_rp) begin
                                n_wp = r_rp; n_pe = r_rp; n_state = S_PUSH;
                            end else begin
                                o_strobe = 1'b1; o_last = 1'b1;
                            end
                        end
                        iepq_pkg::OP_READ: n_state = S_READ;
                        default: begin
                            if (i_ev_type == iepq_pkg::TYPE_SYNC) begin
                                o_strobe = 1'b1; o_last = 1'b1;
                            end else begin
                                n_pe = r_rp; n_i = r_rp; n_dst = r_rp;
                                n_run0 = 1'b0; n_state = S_FRD;
                            end
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (is_rep(r_ev) && r_pe == r_wp) begin
                    o_strobe = 1'b1; o_last = 1'b1; o_status = iepq_pkg::ST_REJECTED;
                    n_state = S_IDLE;
                end else begin
                    mctl.we = 1'b1; waddr = r_wp; wdata = r_ev;
                    n_wp = wp1;
                    n_pst = is_rep(r_ev) ? iepq_pkg::ST_COMPLETE : iepq_pkg::ST_STORED;
                    if (is_rep(r_ev)) n_pe = wp1;
                    if (wp1 == r_rp) begin
                        n_state = S_DROP;
                    end else begin
                        o_strobe = 1'b1; o_last = 1'b1; o_status = n_pst;
                        n_state = S_IDLE;
                    end
                end
            end
            S_DROP: begin
                // overflow: marker two slots behind the write pointer
                mctl.we = 1'b1;
                waddr = (r_wp - AW'(2)) & r_mask;
                wdata = drop_ev;
                n_rp = waddr;
                n_pe = (r_pst == iepq_pkg::ST_COMPLETE) ? r_wp : waddr;
                o_strobe = 1'b1; o_last = 1'b1; o_status = r_pst;
                n_state = S_IDLE;
            end
            S_READ: begin
                // show the event fetched last cycle, fetch the next one
                if (r_rd_pend) begin
                    o_strobe = 1'b1; o_out_valid = 1'b1;
                    o_out_sec = rdata.sec; o_out_usec = rdata.usec;
                    o_out_type = rdata.ev_type; o_out_code = rdata.code;
                    o_out_value = rdata.value;
                end
                if (r_cnt < r_lim && r_pe != r_rp) begin
                    mctl.re = 1'b1; raddr = r_rp;
                    n_rp = rd_next; n_cnt = r_cnt + 1'b1; n_rd_pend = 1'b1;
                end else begin
                    o_strobe = 1'b1; o_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                if (r_i == r_wp) begin
                    n_wp = r_dst; n_state = S_FDONE;
                end else begin
                    mctl.re = 1'b1; raddr = r_i; n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_i = (r_i + 1'b1) & r_mask;
                n_state = S_FRD;
                if (!(rdata.ev_type == r_ftype) && !(is_rep(rdata) && r_run0)) begin
                    mctl.we = (r_dst != r_i); waddr = r_dst; wdata = rdata;
                    n_dst = (r_dst + 1'b1) & r_mask;
                    n_run0 = 1'b0;
                    if (is_rep(rdata)) begin
                        n_run0 = 1'b1; n_pe = n_dst;
                    end
                end
            end
            S_FDONE: begin
                o_strobe = 1'b1; o_last = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_wp <= '0; r_rp <= '0; r_pe <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_rd_pend <= n_rd_pend;
            if (i_cfg_we) begin
                r_wp <= '0; r_rp <= '0; r_pe <= '0;
            end else begin
                r_wp <= n_wp; r_rp <= n_rp; r_pe <= n_pe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_dst <= n_dst; r_run0 <= n_run0; r_cnt <= n_cnt;
        r_lim <= n_lim; r_ev <= n_ev; r_ftype <= n_ftype; r_pst <= n_pst;
    end

    // a strobe with valid data only comes out of the read walk
    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_READ && o_strobe)) else $error("valid outside read");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> (r_state == S_IDLE)) else $error("last not final");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == iepq_pkg::OP_READ) |=> busy) else $error("read not taken");
endmodule

/* hdl/iepq_ram.sv */
// ----------------------------------------------------------------------------
// iepq_ram
// event storage, one write and one registered read port
// ----------------------------------------------------------------------------
module iepq_ram #(
    parameter int DEPTH = iepq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  iepq_pkg::t_mem_ctl    i_ctl,
    input  logic [AW-1:0]         i_waddr,
    input  iepq_pkg::t_event      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output iepq_pkg::t_event      o_rdata
);
    iepq_pkg::t_event r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
